// File: rtl/windowed_stationary_detector_core_assert.svh
// Assertion macros shared by the detector RTL
`ifndef WINDOWED_STATIONARY_DETECTOR_CORE_ASSERT_SVH
`define WINDOWED_STATIONARY_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define WSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define WSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/wsd_pkg.sv
package wsd_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int VLIM_W   = 16;
    localparam int VARL_W   = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int OPC_W    = 2;
    localparam int VERD_W   = 3;

    // Shift-add multiplier sizes
    localparam int PROD_W   = 64;
    localparam int MUL_B_W  = 32;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    // Default buffer depths
    localparam int VELOCITY_DEPTH_DEF = 64;
    localparam int RANGE_DEPTH_DEF    = 64;

    localparam int MIN_RANGES = 3;

    // Opcodes
    localparam logic [OPC_W-1:0] OP_PUSH_V = 2'd0;
    localparam logic [OPC_W-1:0] OP_PUSH_R = 2'd1;
    localparam logic [OPC_W-1:0] OP_QUERY  = 2'd2;

    // Verdict codes
    localparam logic [VERD_W-1:0] V_STILL    = 3'd0;
    localparam logic [VERD_W-1:0] V_NO_VEL   = 3'd1;
    localparam logic [VERD_W-1:0] V_FEW_RNG  = 3'd2;
    localparam logic [VERD_W-1:0] V_VEL_MOVE = 3'd3;
    localparam logic [VERD_W-1:0] V_VAR_HIGH = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VLIM   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VARL   = 2'd2;

    // Register reset values
    localparam logic [TIME_W-1:0] WINDOW_RST = 32'd2000000;
    localparam logic [VLIM_W-1:0] VLIM_RST   = 16'd50;
    localparam logic [VARL_W-1:0] VARL_RST   = 32'd100;

    // Multiplier jobs
    localparam logic [1:0] MUL_N_SQ   = 2'd0;  // n * sum(r^2)
    localparam logic [1:0] MUL_SUM_SQ = 2'd1;  // sum(r) * sum(r)
    localparam logic [1:0] MUL_LIM_N  = 2'd2;  // limit * n
    localparam logic [1:0] MUL_LIM_NN = 2'd3;  // (limit * n) * n

    typedef struct packed {
        logic       push_v;
        logic       push_r;
        logic       q_start;
        logic       rd_v;
        logic       rd_r;
        logic       ridx_clr;
        logic       mul_start;
        logic [1:0] mul_sel;
    } t_cmd;

    typedef struct packed {
        logic vfill_zero;
        logic rfill_zero;
        logic v_last;
        logic r_last;
        logic v_any;
        logic v_moving;
        logic n_lt3;
        logic var_high;
        logic mul_busy;
    } t_status;

endpackage

// File: rtl/wsd_datapath.sv
module wsd_datapath #(
    parameter int VELOCITY_DEPTH = 64,
    parameter int RANGE_DEPTH    = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  wsd_pkg::t_cmd                  i_cmd,
    output wsd_pkg::t_status               o_status,
    input  logic [wsd_pkg::SAMPLE_W-1:0]   i_sample_value,
    input  logic [wsd_pkg::TIME_W-1:0]     i_timestamp,
    input  logic                           i_cfg_wr_en,
    input  logic [wsd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wsd_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import wsd_pkg::*;

    localparam int VAW = (VELOCITY_DEPTH > 1) ? $clog2(VELOCITY_DEPTH) : 1;
    localparam int RAW = (RANGE_DEPTH > 1) ? $clog2(RANGE_DEPTH) : 1;
    localparam int VFW = $clog2(VELOCITY_DEPTH + 1);
    localparam int RFW = $clog2(RANGE_DEPTH + 1);
    localparam int RSUMW = SAMPLE_W + RFW;
    localparam int RSQW  = 2 * SAMPLE_W + RFW;
    localparam int ENT_W = SAMPLE_W + TIME_W;

    // Configuration registers
    logic [TIME_W-1:0] r_window;
    logic [VLIM_W-1:0] r_vlim;
    logic [VARL_W-1:0] r_varl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RST;
            r_vlim   <= VLIM_RST;
            r_varl   <= VARL_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_WINDOW: r_window <= i_cfg_wdata[TIME_W-1:0];
                REG_VLIM:   r_vlim   <= i_cfg_wdata[VLIM_W-1:0];
                REG_VARL:   r_varl   <= i_cfg_wdata[VARL_W-1:0];
                default: ;
            endcase
        end
    end

    // Sample stores: {value, time}
    logic [ENT_W-1:0] v_mem [VELOCITY_DEPTH];
    logic [ENT_W-1:0] r_mem [RANGE_DEPTH];
    logic [ENT_W-1:0] r_v_rd;
    logic [ENT_W-1:0] r_r_rd;

    logic [VAW-1:0] r_vhead, r_vidx;
    logic [RAW-1:0] r_rhead, r_ridx;
    logic [VFW-1:0] r_vfill;
    logic [RFW-1:0] r_rfill;
    logic           r_v_rd_vld, r_r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_v) begin
            v_mem[r_vhead] <= {i_sample_value, i_timestamp};
        end
        if (i_cmd.rd_v) begin
            r_v_rd <= v_mem[r_vidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_r) begin
            r_mem[r_rhead] <= {i_sample_value, i_timestamp};
        end
        if (i_cmd.rd_r) begin
            r_r_rd <= r_mem[r_ridx];
        end
    end

    // Ring pointers, fill counts and walk indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vhead    <= '0;
            r_rhead    <= '0;
            r_vfill    <= '0;
            r_rfill    <= '0;
            r_vidx     <= '0;
            r_ridx     <= '0;
            r_v_rd_vld <= 1'b0;
            r_r_rd_vld <= 1'b0;
        end else begin
            r_v_rd_vld <= i_cmd.rd_v;
            r_r_rd_vld <= i_cmd.rd_r;
            if (i_cmd.push_v) begin
                r_vhead <= (r_vhead == VAW'(VELOCITY_DEPTH - 1)) ? '0 : r_vhead + 1'b1;
                if (r_vfill != VFW'(VELOCITY_DEPTH)) r_vfill <= r_vfill + 1'b1;
            end
            if (i_cmd.push_r) begin
                r_rhead <= (r_rhead == RAW'(RANGE_DEPTH - 1)) ? '0 : r_rhead + 1'b1;
                if (r_rfill != RFW'(RANGE_DEPTH)) r_rfill <= r_rfill + 1'b1;
            end
            if (i_cmd.q_start) r_vidx <= '0;
            else if (i_cmd.rd_v) r_vidx <= r_vidx + 1'b1;
            if (i_cmd.ridx_clr) r_ridx <= '0;
            else if (i_cmd.rd_r) r_ridx <= r_ridx + 1'b1;
        end
    end

    // Cutoff and accumulators
    logic [TIME_W-1:0] r_cutoff;
    logic              r_vany, r_vmove;
    logic [RFW-1:0]    r_n;
    logic [RSUMW-1:0]  r_rsum;
    logic [RSQW-1:0]   r_rsq;
    logic [SAMPLE_W-1:0] rd_rval;
    logic [2*SAMPLE_W-1:0] rd_rsq;

    assign rd_rval = r_r_rd[ENT_W-1:TIME_W];
    assign rd_rsq  = rd_rval * rd_rval;

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_start) begin
            r_cutoff <= (i_timestamp >= r_window) ? i_timestamp - r_window : '0;
            r_vany   <= 1'b0;
            r_vmove  <= 1'b0;
            r_n      <= '0;
            r_rsum   <= '0;
            r_rsq    <= '0;
        end else begin
            if (r_v_rd_vld && r_v_rd[TIME_W-1:0] >= r_cutoff) begin
                r_vany <= 1'b1;
                if (r_v_rd[ENT_W-1:TIME_W] >= r_vlim) r_vmove <= 1'b1;
            end
            if (r_r_rd_vld && r_r_rd[TIME_W-1:0] >= r_cutoff) begin
                r_n    <= r_n + 1'b1;
                r_rsum <= r_rsum + RSUMW'(rd_rval);
                r_rsq  <= r_rsq + RSQW'(rd_rsq);
            end
        end
    end

    // Shared shift-add multiplier, one multiplier bit per cycle
    logic [PROD_W-1:0]    r_ma, r_macc, n_macc;
    logic [MUL_B_W-1:0]   r_mb;
    logic [MUL_CNT_W-1:0] r_mcnt;
    logic                 r_mbusy;
    logic [1:0]           r_msel;
    logic [PROD_W-1:0]    r_p_nsq, r_p_ss, r_p_ln, r_p_lnn;

    assign n_macc = r_macc + (r_mb[0] ? r_ma : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
        end else if (i_cmd.mul_start) begin
            r_mbusy <= 1'b1;
        end else if (r_mbusy && r_mcnt == MUL_CNT_W'(MUL_B_W - 1)) begin
            r_mbusy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_macc <= '0;
            r_mcnt <= '0;
            r_msel <= i_cmd.mul_sel;
            case (i_cmd.mul_sel)
                MUL_N_SQ: begin
                    r_ma <= PROD_W'(r_rsq);
                    r_mb <= MUL_B_W'(r_n);
                end
                MUL_SUM_SQ: begin
                    r_ma <= PROD_W'(r_rsum);
                    r_mb <= MUL_B_W'(r_rsum);
                end
                MUL_LIM_N: begin
                    r_ma <= PROD_W'(r_varl);
                    r_mb <= MUL_B_W'(r_n);
                end
                default: begin
                    r_ma <= r_p_ln;
                    r_mb <= MUL_B_W'(r_n);
                end
            endcase
        end else if (r_mbusy) begin
            r_macc <= n_macc;
            r_ma   <= r_ma << 1;
            r_mb   <= r_mb >> 1;
            r_mcnt <= r_mcnt + 1'b1;
            if (r_mcnt == MUL_CNT_W'(MUL_B_W - 1)) begin
                case (r_msel)
                    MUL_N_SQ:   r_p_nsq <= n_macc;
                    MUL_SUM_SQ: r_p_ss  <= n_macc;
                    MUL_LIM_N:  r_p_ln  <= n_macc;
                    default:    r_p_lnn <= n_macc;
                endcase
            end
        end
    end

    // Status back to the controller
    assign o_status.vfill_zero = (r_vfill == '0);
    assign o_status.rfill_zero = (r_rfill == '0);
    assign o_status.v_last     = (VFW'(r_vidx) + 1'b1 == r_vfill);
    assign o_status.r_last     = (RFW'(r_ridx) + 1'b1 == r_rfill);
    assign o_status.v_any      = r_vany;
    assign o_status.v_moving   = r_vmove;
    assign o_status.n_lt3      = (r_n < RFW'(MIN_RANGES));
    assign o_status.var_high   = ((r_p_nsq - r_p_ss) >= r_p_lnn);
    assign o_status.mul_busy   = r_mbusy;

endmodule

// File: rtl/wsd_ctrl.sv
module wsd_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [wsd_pkg::OPC_W-1:0]     i_opcode,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_stationary,
    output logic [wsd_pkg::VERD_W-1:0]    o_verdict,
    output wsd_pkg::t_cmd                 o_cmd,
    input  wsd_pkg::t_status              i_status
);
    import wsd_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_VWALK  = 4'd1;
    localparam logic [3:0] S_VDRAIN = 4'd2;
    localparam logic [3:0] S_VCHK   = 4'd3;
    localparam logic [3:0] S_RWALK  = 4'd4;
    localparam logic [3:0] S_RDRAIN = 4'd5;
    localparam logic [3:0] S_RCHK   = 4'd6;
    localparam logic [3:0] S_MUL0   = 4'd7;
    localparam logic [3:0] S_MUL1   = 4'd8;
    localparam logic [3:0] S_MUL2   = 4'd9;
    localparam logic [3:0] S_MUL3   = 4'd10;
    localparam logic [3:0] S_CMP    = 4'd11;
    localparam logic [3:0] S_RES    = 4'd12;

    logic [3:0]        r_state, n_state;
    logic [VERD_W-1:0] r_verdict, n_verdict;
    logic              r_out_vld;
    logic [VERD_W-1:0] r_out_verdict;
    logic              accept, out_load;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;
    assign out_load = (r_state == S_RES) && (!r_out_vld || !i_stall);

    // Next state and datapath commands
    always_comb begin
        n_state   = r_state;
        n_verdict = r_verdict;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.push_v  = (i_opcode == OP_PUSH_V);
                    o_cmd.push_r  = (i_opcode == OP_PUSH_R);
                    if (i_opcode == OP_QUERY) begin
                        o_cmd.q_start = 1'b1;
                        if (i_status.vfill_zero) begin
                            n_verdict = V_NO_VEL;
                            n_state   = S_RES;
                        end else begin
                            n_state = S_VWALK;
                        end
                    end
                end
            end
            S_VWALK: begin
                o_cmd.rd_v = 1'b1;
                if (i_status.v_last) n_state = S_VDRAIN;
            end
            S_VDRAIN: n_state = S_VCHK;
            S_VCHK: begin
                o_cmd.ridx_clr = 1'b1;
                if (!i_status.v_any) begin
                    n_verdict = V_NO_VEL;
                    n_state   = S_RES;
                end else if (i_status.rfill_zero) begin
                    n_verdict = V_FEW_RNG;
                    n_state   = S_RES;
                end else begin
                    n_state = S_RWALK;
                end
            end
            S_RWALK: begin
                o_cmd.rd_r = 1'b1;
                if (i_status.r_last) n_state = S_RDRAIN;
            end
            S_RDRAIN: n_state = S_RCHK;
            S_RCHK: begin
                if (i_status.n_lt3) begin
                    n_verdict = V_FEW_RNG;
                    n_state   = S_RES;
                end else if (i_status.v_moving) begin
                    n_verdict = V_VEL_MOVE;
                    n_state   = S_RES;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MUL_N_SQ;
                    n_state         = S_MUL0;
                end
            end
            S_MUL0: begin
                if (!i_status.mul_busy) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MUL_SUM_SQ;
                    n_state         = S_MUL1;
                end
            end
            S_MUL1: begin
                if (!i_status.mul_busy) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MUL_LIM_N;
                    n_state         = S_MUL2;
                end
            end
            S_MUL2: begin
                if (!i_status.mul_busy) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MUL_LIM_NN;
                    n_state         = S_MUL3;
                end
            end
            S_MUL3: begin
                if (!i_status.mul_busy) n_state = S_CMP;
            end
            S_CMP: begin
                n_verdict = i_status.var_high ? V_VAR_HIGH : V_STILL;
                n_state   = S_RES;
            end
            S_RES: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_verdict <= n_verdict;
        if (out_load) r_out_verdict <= r_verdict;
    end

    // Output register: holds a result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_verdict    = r_out_verdict;
    assign o_stationary = (r_out_verdict == V_STILL);

endmodule

// File: rtl/windowed_stationary_detector_core.sv
// Pushes (velocity or range) produce no result.
// A query reads one store entry per cycle, then, unless an early verdict is
// reached, runs four 32-step shift-add multiplies; a result waits in an
// output register and the next pushes are taken meanwhile.
// Reset (synchronous, active low) empties both buffers, clears control and
// loads window 2000000 us, velocity limit 50, variance limit 100.
module windowed_stationary_detector_core #(
    parameter int VELOCITY_DEPTH = wsd_pkg::VELOCITY_DEPTH_DEF,
    parameter int RANGE_DEPTH    = wsd_pkg::RANGE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [wsd_pkg::OPC_W-1:0]     i_opcode,
    input  logic [wsd_pkg::SAMPLE_W-1:0]  i_sample_value,
    input  logic [wsd_pkg::TIME_W-1:0]    i_timestamp,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_stationary,
    output logic [wsd_pkg::VERD_W-1:0]    o_verdict,
    input  logic                          i_cfg_wr_en,
    input  logic [wsd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wsd_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import wsd_pkg::*;

    t_cmd    s_cmd;
    t_status s_status;

    wsd_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_stationary (o_stationary),
        .o_verdict    (o_verdict),
        .o_cmd        (s_cmd),
        .i_status     (s_status)
    );

    wsd_datapath #(
        .VELOCITY_DEPTH (VELOCITY_DEPTH),
        .RANGE_DEPTH    (RANGE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (s_cmd),
        .o_status       (s_status),
        .i_sample_value (i_sample_value),
        .i_timestamp    (i_timestamp),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

`include "windowed_stationary_detector_core_assert.svh"

    // stationary flag agrees with the verdict code
    `WSD_ASSERT_NOW(a_stat_matches, i_clk, i_rst_n, o_valid, o_stationary == (o_verdict == V_STILL), "stationary flag disagrees with verdict")
    // an accepted query keeps the input side busy next cycle
    `WSD_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, i_valid && !o_stall && i_opcode == OP_QUERY, o_stall, "query did not block input")
    // the multiplier only runs inside a query
    `WSD_ASSERT_NOW(a_mul_in_query, i_clk, i_rst_n, s_status.mul_busy, o_stall, "multiplier busy while idle")

endmodule
